[src/hrfp_pkg.sv]
// ----------------------------------------------------------------------------
// hrfp_pkg
// Shared types and constants for the hit report frame parser.
// ----------------------------------------------------------------------------
package hrfp_pkg;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_RECORD = 2'd0;
    localparam kind_t KIND_GOOD   = 2'd1;
    localparam kind_t KIND_BAD    = 2'd2;
    localparam kind_t KIND_HEADER = 2'd3;

    localparam logic [7:0] HDR_BYTE = 8'hAA;
    localparam int         REC_LEN  = 7;

    // Bytes of a record held before its last byte arrives.
    localparam int REC_HOLD_BYTES = REC_LEN - 1;
    localparam int REC_HOLD_W     = 8 * REC_HOLD_BYTES;

    typedef logic [2:0]            rec_pos_t;
    typedef logic [REC_HOLD_W-1:0] rec_hold_t;

endpackage

[src/hrfp_if.sv]
// ----------------------------------------------------------------------------
// hrfp_rx_if / hrfp_res_if
// Valid/ready channels for received bytes and for parser results.
// ----------------------------------------------------------------------------
interface hrfp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       packet_start;

    modport source (output valid, output rx_byte, output packet_start, input ready);
    modport sink   (input valid, input rx_byte, input packet_start, output ready);
endinterface

interface hrfp_res_if
    import hrfp_pkg::*;
;
    logic        valid;
    logic        ready;
    kind_t       result_kind;
    logic [7:0]  record_index;
    logic [15:0] fish_id;
    logic [7:0]  player_id;
    logic [31:0] payout;
    logic [7:0]  frame_count;
    logic [7:0]  header_seen;

    modport source (output valid, output result_kind, output record_index,
                    output fish_id, output player_id, output payout,
                    output frame_count, output header_seen, input ready);
    modport sink   (input valid, input result_kind, input record_index,
                    input fish_id, input player_id, input payout,
                    input frame_count, input header_seen, output ready);
endinterface

[src/hit_report_frame_parser_unit.sv]
// ----------------------------------------------------------------------------
// hit_report_frame_parser_unit
// Parses hit-report frames from a serial byte stream, one byte per beat.
// ----------------------------------------------------------------------------
// Takes one byte per clock cycle unless the result sink stalls; parses frames
// of the form: header 0xAA, count byte N, N records of 7 bytes (16-bit fish
// id, player byte, 32-bit payout, little-endian), then an 8-bit additive
// checksum over all earlier bytes. Each record is reported on its last byte;
// the checksum byte reports frame good or bad; a packet that does not open
// with 0xAA reports a bad header and is ignored until the next packet start,
// which also aborts any unfinished frame. The parse state updates at the input
// beat and the result, if any, lands in an output register in the same edge.
// A new byte is taken whenever that register is empty or is being drained in
// the same cycle, so with the sink ready the rate is one byte per clock.
// ----------------------------------------------------------------------------
module hit_report_frame_parser_unit
    import hrfp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    hrfp_rx_if.sink      rx,
    hrfp_res_if.source   res
);

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_COUNT   = 2'd1;
    localparam logic [1:0] PH_RECORDS = 2'd2;
    localparam logic [1:0] PH_CHECK   = 2'd3;

    localparam rec_pos_t LAST_POS = rec_pos_t'(REC_LEN - 1);

    logic [1:0] phase_reg,        phase_next;
    logic [7:0] records_left_reg, records_left_next;
    rec_pos_t   pos_reg,          pos_next;
    logic [7:0] cur_rec_reg,      cur_rec_next;
    logic [7:0] sum_reg,          sum_next;
    rec_hold_t  hold_reg,         hold_next;
    logic [7:0] count_reg,        count_next;

    logic        out_valid_reg;
    kind_t       kind_reg,   kind_next;
    logic [7:0]  idx_reg,    idx_next;
    logic [15:0] fid_reg,    fid_next;
    logic [7:0]  pid_reg,    pid_next;
    logic [31:0] pay_reg,    pay_next;
    logic [7:0]  cnt_reg,    cnt_next;
    logic [7:0]  hdr_reg,    hdr_next;
    logic        emit;

    logic accept;
    logic [7:0] b;

    assign rx.ready = !out_valid_reg || res.ready;
    assign accept   = rx.valid && rx.ready;
    assign b        = rx.rx_byte;

    always_comb
    begin
        phase_next        = phase_reg;
        records_left_next = records_left_reg;
        pos_next          = pos_reg;
        cur_rec_next      = cur_rec_reg;
        sum_next          = sum_reg;
        hold_next         = hold_reg;
        count_next        = count_reg;

        emit      = 1'b0;
        kind_next = KIND_RECORD;
        idx_next  = '0;
        fid_next  = '0;
        pid_next  = '0;
        pay_next  = '0;
        cnt_next  = count_reg;
        hdr_next  = HDR_BYTE;

        if (rx.packet_start)
        begin
            // Abort whatever was in flight and take this byte as a header.
            records_left_next = '0;
            pos_next          = '0;
            cur_rec_next      = '0;
            hold_next         = '0;
            count_next        = '0;
            if (b == HDR_BYTE)
            begin
                sum_next   = b;
                phase_next = PH_COUNT;
            end
            else
            begin
                sum_next   = '0;
                phase_next = PH_IDLE;
                emit       = 1'b1;
                kind_next  = KIND_HEADER;
                cnt_next   = '0;
                hdr_next   = b;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_COUNT:
                begin
                    count_next        = b;
                    records_left_next = b;
                    sum_next          = sum_reg + b;
                    cur_rec_next      = '0;
                    pos_next          = '0;
                    hold_next         = '0;
                    phase_next        = (b != 8'd0) ? PH_RECORDS : PH_CHECK;
                end
                PH_RECORDS:
                begin
                    sum_next = sum_reg + b;
                    if (pos_reg < LAST_POS)
                    begin
                        hold_next[{pos_reg, 3'b000} +: 8] = b;
                        pos_next = pos_reg + rec_pos_t'(1);
                    end
                    else
                    begin
                        emit     = 1'b1;
                        idx_next = cur_rec_reg;
                        fid_next = hold_reg[15:0];
                        pid_next = hold_reg[23:16];
                        pay_next = {b, hold_reg[47:24]};
                        cur_rec_next      = cur_rec_reg + 8'd1;
                        records_left_next = records_left_reg - 8'd1;
                        pos_next          = '0;
                        hold_next         = '0;
                        if (records_left_reg == 8'd1)
                        begin
                            phase_next = PH_CHECK;
                        end
                    end
                end
                PH_CHECK:
                begin
                    emit       = 1'b1;
                    kind_next  = (sum_reg == b) ? KIND_GOOD : KIND_BAD;
                    phase_next = PH_IDLE;
                end
                default:
                begin
                    // Drop bytes outside a frame.
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            records_left_reg <= '0;
            pos_reg          <= '0;
            cur_rec_reg      <= '0;
            sum_reg          <= '0;
            hold_reg         <= '0;
            count_reg        <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg        <= phase_next;
                records_left_reg <= records_left_next;
                pos_reg          <= pos_next;
                cur_rec_reg      <= cur_rec_next;
                sum_reg          <= sum_next;
                hold_reg         <= hold_next;
                count_reg        <= count_next;
            end
            if (accept && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload: load on a beat that produces a result, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            kind_reg <= kind_next;
            idx_reg  <= idx_next;
            fid_reg  <= fid_next;
            pid_reg  <= pid_next;
            pay_reg  <= pay_next;
            cnt_reg  <= cnt_next;
            hdr_reg  <= hdr_next;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.result_kind  = kind_reg;
    assign res.record_index = idx_reg;
    assign res.fish_id      = fid_reg;
    assign res.player_id    = pid_reg;
    assign res.payout       = pay_reg;
    assign res.frame_count  = cnt_reg;
    assign res.header_seen  = hdr_reg;

endmodule
